[rtl/ozstp_pkg.sv]
// shared widths, constants and transfer types for the ozone stp cubic correction
package ozstp_pkg;

   localparam int FRACTION_BITS = 16;

   localparam int OZONE_W = 31;
   localparam int PRESS_W = 28;
   localparam int TEMP_W  = 24;
   localparam int COEF_W  = 32;
   localparam int OUT_W   = 31;

   localparam int COEF_COUNT = 4;
   localparam int CSR_AW     = $clog2(COEF_COUNT * 4);
   localparam int REG_IDX_W  = $clog2(COEF_COUNT);

   localparam logic [REG_IDX_W-1:0] REG_CONSTANT = REG_IDX_W'(0);
   localparam logic [REG_IDX_W-1:0] REG_LINEAR   = REG_IDX_W'(1);
   localparam logic [REG_IDX_W-1:0] REG_SQUARE   = REG_IDX_W'(2);
   localparam logic [REG_IDX_W-1:0] REG_CUBE     = REG_IDX_W'(3);

   // 1013.16 hPa and 273.15 K in hundredths
   localparam int    STD_PRESS_CENTI = 101316;
   localparam int    STD_W           = 17;
   localparam int    KELVIN_CENTI    = 27315;
   localparam int    DEN_K           = 100 * KELVIN_CENTI;
   localparam int    DEN_K_W         = 22;
   localparam longint KELVIN_SCALED  = longint'(KELVIN_CENTI) << FRACTION_BITS;

   // |ozone| * 101316
   localparam int AMAG_W = OZONE_W + STD_W - 1;
   localparam int A_LO_W = AMAG_W / 2;
   // 100 * temp + 27315 << F, signed and magnitude
   localparam int FS_W   = ((FRACTION_BITS + 16 > 31) ? FRACTION_BITS + 16 : 31) + 1;
   localparam int FM_W   = FS_W - 1;
   localparam int NUM_W  = AMAG_W + FM_W;
   localparam int DEN_W  = PRESS_W - 1 + DEN_K_W;

   // divisor is at least 2^(DEN_K_W-1) for a positive pressure
   localparam int QUO_BITS   = NUM_W - (DEN_K_W - 1);
   localparam int DIV_STEP   = 2;
   localparam int DIV_STAGES = (QUO_BITS + DIV_STEP - 1) / DIV_STEP;
   localparam int QUO_W      = DIV_STAGES * DIV_STEP;

   localparam int MAG_W  = 62;
   localparam int HALF_W = MAG_W / 2;
   localparam int H_W    = 64;
   localparam int HORNER_STAGES = 5;

   localparam logic [63:0] SAT_LIM = 64'h3fff_ffff_ffff_ffff;
   localparam logic signed [H_W-1:0] ONE_H     = H_W'(64'sd1 <<< FRACTION_BITS);
   localparam logic signed [H_W-1:0] OUT_MAX_H = H_W'(64'sd2147483647);
   localparam logic [COEF_W-1:0]     COEF_ONE  = COEF_W'(64'd1 << FRACTION_BITS);

   typedef struct packed {
      logic signed [OZONE_W-1:0] ozone_raw;
      logic signed [PRESS_W-1:0] pressure_hpa;
      logic signed [TEMP_W-1:0]  temperature_c;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] ozone_corrected;
      logic             pressure_invalid;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic             invalid;
      logic             neg;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_in_type;

   typedef struct packed {
      logic             valid;
      logic             invalid;
      logic             neg;
      logic [QUO_W-1:0] quo;
   } div_out_type;

   typedef struct packed {
      logic                  valid;
      logic                  invalid;
      logic                  s_neg;
      logic [MAG_W-1:0]      s_mag;
      logic signed [H_W-1:0] h;
   } hstep_type;

endpackage

[rtl/ozstp_div.sv]
// pipelined restoring divider for the pressure and temperature scale
module ozstp_div (
   input  logic                    clock,
   input  logic                    reset,
   input  ozstp_pkg::div_in_type   div_in,
   output ozstp_pkg::div_out_type  div_out
);

   localparam int STAGES = ozstp_pkg::DIV_STAGES;
   localparam int STEP   = ozstp_pkg::DIV_STEP;
   localparam int DW     = ozstp_pkg::DEN_W;
   localparam int QW     = ozstp_pkg::QUO_W;
   localparam int NW     = ozstp_pkg::NUM_W;

   logic          valid_ff   [STAGES];
   logic          invalid_ff [STAGES];
   logic          neg_ff     [STAGES];
   logic [DW-1:0] rem_ff     [STAGES];
   logic [QW-1:0] bits_ff    [STAGES];
   logic [QW-1:0] quo_ff     [STAGES];
   logic [DW-1:0] den_ff     [STAGES];

   logic          src_valid   [STAGES+1];
   logic          src_invalid [STAGES+1];
   logic          src_neg     [STAGES+1];
   logic [DW-1:0] src_rem     [STAGES+1];
   logic [QW-1:0] src_bits    [STAGES+1];
   logic [QW-1:0] src_quo     [STAGES+1];
   logic [DW-1:0] src_den     [STAGES+1];

   // top numerator bits are already below the divisor
   assign src_valid[0]   = div_in.valid;
   assign src_invalid[0] = div_in.invalid;
   assign src_neg[0]     = div_in.neg;
   assign src_rem[0]     = DW'(div_in.num[NW-1:QW]);
   assign src_bits[0]    = div_in.num[QW-1:0];
   assign src_quo[0]     = '0;
   assign src_den[0]     = div_in.den;

   for (genvar g = 0; g < STAGES; g++) begin : g_stage
      logic [DW-1:0] rem_in;
      logic [QW-1:0] bits_in;
      logic [QW-1:0] quo_in;

      always_comb begin
         logic [DW:0] trial;
         rem_in  = src_rem[g];
         bits_in = src_bits[g];
         quo_in  = src_quo[g];
         for (int i = 0; i < STEP; i++) begin
            trial   = {rem_in, bits_in[QW-1]};
            bits_in = bits_in << 1;
            if (trial >= {1'b0, src_den[g]}) begin
               trial  = trial - {1'b0, src_den[g]};
               quo_in = {quo_in[QW-2:0], 1'b1};
            end else begin
               quo_in = {quo_in[QW-2:0], 1'b0};
            end
            rem_in = trial[DW-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g]   <= src_valid[g];
            invalid_ff[g] <= src_invalid[g];
            neg_ff[g]     <= src_neg[g];
            rem_ff[g]     <= rem_in;
            bits_ff[g]    <= bits_in;
            quo_ff[g]     <= quo_in;
            den_ff[g]     <= src_den[g];
         end
      end

      assign src_valid[g+1]   = valid_ff[g];
      assign src_invalid[g+1] = invalid_ff[g];
      assign src_neg[g+1]     = neg_ff[g];
      assign src_rem[g+1]     = rem_ff[g];
      assign src_bits[g+1]    = bits_ff[g];
      assign src_quo[g+1]     = quo_ff[g];
      assign src_den[g+1]     = den_ff[g];
   end

   assign div_out.valid   = src_valid[STAGES];
   assign div_out.invalid = src_invalid[STAGES];
   assign div_out.neg     = src_neg[STAGES];
   assign div_out.quo     = src_quo[STAGES];

endmodule

[rtl/ozstp_horner.sv]
// one pipelined horner step: h = coef + ((s * h) >> fraction bits), saturating
module ozstp_horner (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ozstp_pkg::hstep_type                 step_in,
   input  logic signed [ozstp_pkg::COEF_W-1:0]  coef,
   output ozstp_pkg::hstep_type                 step_out
);

   localparam int HW     = ozstp_pkg::HALF_W;
   localparam int MW     = ozstp_pkg::MAG_W;
   localparam int H_W    = ozstp_pkg::H_W;
   localparam int PP_W   = 2 * HW;
   localparam int MID_W  = PP_W + 1;
   localparam int PROD_W = 4 * HW;
   localparam logic signed [H_W-1:0] SAT_POS = H_W'(ozstp_pkg::SAT_LIM);
   localparam logic signed [H_W-1:0] SAT_NEG = -SAT_POS;

   ozstp_pkg::hstep_type a_ff, b_ff, c_ff, d_ff, e_ff;
   ozstp_pkg::hstep_type e_in;

   logic [MW-1:0]     mh_a_ff, mh_a_in;
   logic              pneg_a_in, pneg_a_ff, pneg_b_ff, pneg_c_ff, pneg_d_ff;
   logic [PP_W-1:0]   pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   logic [PP_W-1:0]   pp_ll_c_ff, pp_hh_c_ff;
   logic [MID_W-1:0]  mid_c_ff, mid_c_in;
   logic [PROD_W-1:0] full_d, shifted_d;
   logic [MW-1:0]     m_d_ff, m_d_in;
   logic signed [H_W-1:0] cx, mx, sum;

   always_comb begin
      mh_a_in   = step_in.h[H_W-1] ? MW'(-step_in.h) : MW'(step_in.h);
      pneg_a_in = step_in.s_neg ^ step_in.h[H_W-1];
   end

   assign mid_c_in = MID_W'(pp_lh_ff) + MID_W'(pp_hl_ff);

   always_comb begin
      full_d    = {pp_hh_c_ff, pp_ll_c_ff} + (PROD_W'(mid_c_ff) << HW);
      shifted_d = full_d >> ozstp_pkg::FRACTION_BITS;
      m_d_in    = (shifted_d > PROD_W'(ozstp_pkg::SAT_LIM)) ?
                  MW'(ozstp_pkg::SAT_LIM) : shifted_d[MW-1:0];
   end

   always_comb begin
      cx   = H_W'(coef);
      mx   = $signed(H_W'(m_d_ff));
      sum  = pneg_d_ff ? (cx - mx) : (cx + mx);
      e_in = d_ff;
      if (sum > SAT_POS) begin
         e_in.h = SAT_POS;
      end else if (sum < SAT_NEG) begin
         e_in.h = SAT_NEG;
      end else begin
         e_in.h = sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
         b_ff.valid <= 1'b0;
         c_ff.valid <= 1'b0;
         d_ff.valid <= 1'b0;
         e_ff.valid <= 1'b0;
      end else begin
         a_ff      <= step_in;
         mh_a_ff   <= mh_a_in;
         pneg_a_ff <= pneg_a_in;

         b_ff      <= a_ff;
         pneg_b_ff <= pneg_a_ff;
         pp_ll_ff  <= PP_W'(mh_a_ff[HW-1:0])  * PP_W'(a_ff.s_mag[HW-1:0]);
         pp_lh_ff  <= PP_W'(mh_a_ff[HW-1:0])  * PP_W'(a_ff.s_mag[MW-1:HW]);
         pp_hl_ff  <= PP_W'(mh_a_ff[MW-1:HW]) * PP_W'(a_ff.s_mag[HW-1:0]);
         pp_hh_ff  <= PP_W'(mh_a_ff[MW-1:HW]) * PP_W'(a_ff.s_mag[MW-1:HW]);

         c_ff       <= b_ff;
         pneg_c_ff  <= pneg_b_ff;
         mid_c_ff   <= mid_c_in;
         pp_ll_c_ff <= pp_ll_ff;
         pp_hh_c_ff <= pp_hh_ff;

         d_ff      <= c_ff;
         pneg_d_ff <= pneg_c_ff;
         m_d_ff    <= m_d_in;

         e_ff <= e_in;
      end
   end

   assign step_out = e_ff;

endmodule

[rtl/ozone_stp_cubic_correction.sv]
// ozone reading scaled to standard pressure and temperature, then cubic calibration
// throughput: one item per cycle, busy stays low; the 29-stage divider and three
//   five-stage horner steps set the depth
// reset: synchronous, clears all valid bits and loads coefficients 0, 1.0, 0, 0
// results cannot be stalled: each one shows for a single cycle on rsp_valid
module ozone_stp_cubic_correction (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  ozstp_pkg::req_type                req_item,
   output logic                              rsp_valid,
   output ozstp_pkg::rsp_type                rsp_item,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ozstp_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   localparam int OW   = ozstp_pkg::OZONE_W;
   localparam int PW   = ozstp_pkg::PRESS_W;
   localparam int FS_W = ozstp_pkg::FS_W;
   localparam int FM_W = ozstp_pkg::FM_W;
   localparam int AW   = ozstp_pkg::AMAG_W;
   localparam int ALW  = ozstp_pkg::A_LO_W;
   localparam int NW   = ozstp_pkg::NUM_W;
   localparam int DW   = ozstp_pkg::DEN_W;
   localparam int QW   = ozstp_pkg::QUO_W;
   localparam int MW   = ozstp_pkg::MAG_W;
   localparam int H_W  = ozstp_pkg::H_W;
   localparam int PPH_W = (AW - ALW) + FM_W;
   localparam int PPL_W = ALW + FM_W;
   localparam int QX_W  = QW + MW;
   localparam int LATENCY = 4 + ozstp_pkg::DIV_STAGES + 1
                            + 3 * ozstp_pkg::HORNER_STAGES + 1;

   logic signed [ozstp_pkg::COEF_W-1:0] coef_ff [ozstp_pkg::COEF_COUNT];
   logic [ozstp_pkg::REG_IDX_W-1:0]     csr_idx;
   logic                                csr_write;
   logic                                accept;

   // front stages
   logic                   v1_ff, v2_ff, v3_ff, v4_ff;
   logic                   inval1_ff, inval2_ff, inval3_ff, inval4_ff;
   logic                   oneg1_ff;
   logic                   neg2_ff, neg3_ff, neg4_ff;
   logic [OW-1:0]          omag1_ff, omag1_in;
   logic [PW-2:0]          pu1_ff;
   logic signed [FS_W-1:0] f1_ff, f1_in;
   logic                   inval1_in;
   logic [AW-1:0]          a2_ff;
   logic [FM_W-1:0]        fmag2_ff;
   logic [DW-1:0]          den2_ff, den3_ff, den4_ff;
   logic [PPH_W-1:0]       pph3_ff;
   logic [PPL_W-1:0]       ppl3_ff;
   logic [NW-1:0]          num4_ff;

   ozstp_pkg::div_in_type  div_in;
   ozstp_pkg::div_out_type div_out;
   ozstp_pkg::hstep_type   hs0_ff, hs0_in, hs1, hs2, hs3;
   logic [QX_W-1:0]        quo_x;

   ozstp_pkg::rsp_type     rsp_item_ff, rsp_item_in;
   logic                   rsp_valid_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[ozstp_pkg::CSR_AW-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = coef_ff[csr_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[ozstp_pkg::REG_CONSTANT] <= '0;
         coef_ff[ozstp_pkg::REG_LINEAR]   <= ozstp_pkg::COEF_ONE;
         coef_ff[ozstp_pkg::REG_SQUARE]   <= '0;
         coef_ff[ozstp_pkg::REG_CUBE]     <= '0;
      end else if (csr_write) begin
         coef_ff[csr_idx] <= csr_pwdata;
      end
   end

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      omag1_in  = req_item.ozone_raw[OW-1] ? OW'(-req_item.ozone_raw)
                                           : OW'(req_item.ozone_raw);
      inval1_in = req_item.pressure_hpa[PW-1] || (req_item.pressure_hpa == '0);
      f1_in     = FS_W'(req_item.temperature_c) * FS_W'(100)
                  + FS_W'(ozstp_pkg::KELVIN_SCALED);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff     <= accept;
         omag1_ff  <= omag1_in;
         oneg1_ff  <= req_item.ozone_raw[OW-1];
         pu1_ff    <= req_item.pressure_hpa[PW-2:0];
         inval1_ff <= inval1_in;
         f1_ff     <= f1_in;

         v2_ff     <= v1_ff;
         inval2_ff <= inval1_ff;
         a2_ff     <= AW'(omag1_ff) * AW'(ozstp_pkg::STD_PRESS_CENTI);
         den2_ff   <= DW'(pu1_ff) * DW'(ozstp_pkg::DEN_K);
         fmag2_ff  <= f1_ff[FS_W-1] ? FM_W'(-f1_ff) : FM_W'(f1_ff);
         neg2_ff   <= oneg1_ff ^ f1_ff[FS_W-1];

         // numerator split into two partial products
         v3_ff     <= v2_ff;
         inval3_ff <= inval2_ff;
         neg3_ff   <= neg2_ff;
         den3_ff   <= den2_ff;
         pph3_ff   <= PPH_W'(a2_ff[AW-1:ALW]) * PPH_W'(fmag2_ff);
         ppl3_ff   <= PPL_W'(a2_ff[ALW-1:0]) * PPL_W'(fmag2_ff);

         v4_ff     <= v3_ff;
         inval4_ff <= inval3_ff;
         neg4_ff   <= neg3_ff;
         den4_ff   <= den3_ff;
         num4_ff   <= (NW'(pph3_ff) << ALW) + NW'(ppl3_ff);
      end
   end

   always_comb begin
      div_in.valid   = v4_ff;
      div_in.invalid = inval4_ff;
      div_in.neg     = neg4_ff;
      div_in.num     = num4_ff;
      div_in.den     = den4_ff;
   end

   ozstp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_in  (div_in),
      .div_out (div_out)
   );

   // scale factor magnitude, saturated, and the cubic term as horner start
   always_comb begin
      quo_x          = QX_W'(div_out.quo);
      hs0_in.valid   = div_out.valid;
      hs0_in.invalid = div_out.invalid;
      hs0_in.s_neg   = div_out.neg;
      hs0_in.s_mag   = (quo_x > QX_W'(ozstp_pkg::SAT_LIM)) ?
                       MW'(ozstp_pkg::SAT_LIM) : quo_x[MW-1:0];
      hs0_in.h       = H_W'(coef_ff[ozstp_pkg::REG_CUBE]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hs0_ff.valid <= 1'b0;
      end else begin
         hs0_ff <= hs0_in;
      end
   end

   ozstp_horner u_horner_sq (
      .clock    (clock),
      .reset    (reset),
      .step_in  (hs0_ff),
      .coef     (coef_ff[ozstp_pkg::REG_SQUARE]),
      .step_out (hs1)
   );

   ozstp_horner u_horner_lin (
      .clock    (clock),
      .reset    (reset),
      .step_in  (hs1),
      .coef     (coef_ff[ozstp_pkg::REG_LINEAR]),
      .step_out (hs2)
   );

   ozstp_horner u_horner_const (
      .clock    (clock),
      .reset    (reset),
      .step_in  (hs2),
      .coef     (coef_ff[ozstp_pkg::REG_CONSTANT]),
      .step_out (hs3)
   );

   always_comb begin
      rsp_item_in.pressure_invalid = hs3.invalid;
      if (hs3.invalid) begin
         rsp_item_in.ozone_corrected = '0;
      end else if (hs3.h <= ozstp_pkg::ONE_H) begin
         rsp_item_in.ozone_corrected = '0;
      end else if (hs3.h > ozstp_pkg::OUT_MAX_H) begin
         rsp_item_in.ozone_corrected = ozstp_pkg::OUT_MAX_H[ozstp_pkg::OUT_W-1:0];
      end else begin
         rsp_item_in.ozone_corrected = hs3.h[ozstp_pkg::OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= hs3.valid;
         rsp_item_ff  <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTH
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LATENCY rsp_valid)
      else $error("accepted item did not produce a result on time");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result without a matching accepted item");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.pressure_invalid |-> rsp_item.ozone_corrected == '0)
      else $error("bad pressure result not forced to zero");

   a_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.ozone_corrected == '0)
                 || (rsp_item.ozone_corrected > ozstp_pkg::ONE_H[ozstp_pkg::OUT_W-1:0]))
      else $error("result at or below 1.0 not cleared");
`endif

endmodule
